FILE: hdl/pccq_pkg.sv
// Shared types and constants of the paced coalescing command queue.
// No dependencies; every other file imports this package.
package pccq_pkg;

  localparam int CMD_W    = 8;
  localparam int PORT_PAY_W = 32;
  localparam int QCNT_W   = 4;
  localparam int TIMER_W  = 16;

  localparam logic [TIMER_W-1:0] PACING_RESET = 16'd100;

  // Input op codes
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register index of the pacing interval (word address)
  localparam logic REG_PACING = 1'b0;

  // Control that the sequencer broadcasts to every cell
  typedef struct packed {
    logic             update;     // cells load their next value
    logic             submit;     // item is a submit that goes into the queue
    logic             pop;        // oldest entry leaves the queue
    logic             append;     // new command is written into the queue
    logic [CMD_W-1:0] code;       // command code of the submit
  } pccq_ctl_t;

endpackage

FILE: hdl/pccq_if.sv
// Valid/ready channel interfaces for submit/tick items and result items.
// Depends on pccq_pkg for field widths.
interface pccq_in_if import pccq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [CMD_W-1:0]      command_code;
  logic [PORT_PAY_W-1:0] payload;

  modport source (output valid, output op, output command_code, output payload,
                  input ready);
  modport sink   (input valid, input op, input command_code, input payload,
                  output ready);
endinterface

interface pccq_out_if import pccq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  send_valid;
  logic [CMD_W-1:0]      send_command;
  logic [PORT_PAY_W-1:0] send_payload;
  logic [QCNT_W-1:0]     queued_count;
  logic                  dropped;

  modport source (output valid, output send_valid, output send_command,
                  output send_payload, output queued_count, output dropped,
                  input ready);
  modport sink   (input valid, input send_valid, input send_command,
                  input send_payload, input queued_count, input dropped,
                  output ready);
endinterface

FILE: hdl/paced_coalescing_command_queue_top.sv
// Top level of the paced coalescing command queue: sequencer, pacing timer,
// the chain of queue cells and the result register.
// Depends on pccq_pkg, pccq_if, pccq_cfg and pccq_cell.

// Each accepted submit or tick item yields one result item;
// a new item is taken every cycle while the result register is free or its
// result is taken in the same cycle. Coalescing works in the row of cells:
// every cell compares its code with the submit and, in the same cycle, loads
// from itself, its next or next-but-one neighbor, or the new command, so
// removing a matching entry, popping the oldest one and appending all settle
// together when the cells load. The queue needs no clearing after reset.
module paced_coalescing_command_queue_top import pccq_pkg::*; #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  pccq_in_if.sink     req,
  pccq_out_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [TIMER_W-1:0]      interval;
  logic [TIMER_W-1:0]      reload;
  logic [TIMER_W-1:0]      timer_left;
  logic [TIMER_W-1:0]      timer_left_next;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           kept;
  logic [31:0]             count_wide;
  logic                    accept;
  logic                    enq;
  logic                    pop;
  logic                    drop;
  logic                    send;
  logic                    send_now;
  logic [CMD_W-1:0]        send_cmd;
  logic [PAYLOAD_BITS-1:0] send_pay;
  logic [CMD_W-1:0]        front_cmd;
  logic [PAYLOAD_BITS-1:0] front_pay;
  logic [PAYLOAD_BITS-1:0] new_pay;
  pccq_ctl_t               ctl;

  logic [CMD_W-1:0]        cell_cmd [QUEUE_DEPTH+2];
  logic [PAYLOAD_BITS-1:0] cell_pay [QUEUE_DEPTH+2];
  logic                    pre      [QUEUE_DEPTH+2];

  pccq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .interval (interval)
  );

  // Take an item when the result register is free or drains now
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign new_pay   = PAYLOAD_BITS'(req.payload);
  assign reload    = (interval == '0) ? TIMER_W'(1) : interval;

  // Sequencer: decide queue, pop and timer actions for this item
  always_comb begin
    enq             = 1'b0;
    pop             = 1'b0;
    send_now        = 1'b0;
    timer_left_next = timer_left;
    if (req.op == OP_SUBMIT) begin
      if (timer_left != '0) begin
        enq = 1'b1;
      end else if (count != '0) begin
        enq             = 1'b1;
        pop             = 1'b1;
        timer_left_next = reload;
      end else begin
        send_now        = 1'b1;
        timer_left_next = reload;
      end
    end else if (timer_left != '0) begin
      timer_left_next = timer_left - TIMER_W'(1);
      if ((timer_left == TIMER_W'(1)) && (count != '0)) begin
        pop             = 1'b1;
        timer_left_next = reload;
      end
    end
  end

  // Coalescing leaves at most one match, so kept is count or count - 1
  assign kept       = count - CW'(pre[QUEUE_DEPTH]);
  assign drop       = enq && (kept == DEPTH_C);
  assign ctl.pop    = pop;
  assign ctl.submit = enq;
  assign ctl.append = enq && !drop;
  assign ctl.code   = req.command_code;
  assign ctl.update = accept && (enq || ctl.pop);
  assign count_next = kept + CW'(ctl.append) - CW'(ctl.pop);
  assign count_wide = 32'(count_next);

  // Oldest entry after coalescing: skip a matching front slot, and when
  // nothing else is left the new command itself is the oldest
  assign front_cmd = !pre[1] ? cell_cmd[0] :
                     (kept == '0) ? req.command_code : cell_cmd[1];
  assign front_pay = !pre[1] ? cell_pay[0] :
                     (kept == '0) ? new_pay : cell_pay[1];

  assign send     = send_now || ctl.pop;
  assign send_cmd = send_now ? req.command_code : front_cmd;
  assign send_pay = send_now ? new_pay : front_pay;

  // Chain ends: nothing beyond the last slot, no match before the first
  assign pre[0]                = 1'b0;
  assign pre[QUEUE_DEPTH+1]    = pre[QUEUE_DEPTH];
  assign cell_cmd[QUEUE_DEPTH]   = '0;
  assign cell_pay[QUEUE_DEPTH]   = '0;
  assign cell_cmd[QUEUE_DEPTH+1] = '0;
  assign cell_pay[QUEUE_DEPTH+1] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pccq_cell #(
      .IDX   (i),
      .CW    (CW),
      .PAY_W (PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .kept      (kept),
      .new_pay   (new_pay),
      .next_cmd  (cell_cmd[i+1]),
      .next_pay  (cell_pay[i+1]),
      .next2_cmd (cell_cmd[i+2]),
      .next2_pay (cell_pay[i+2]),
      .pre_in    (pre[i]),
      .pre_next  (pre[i+2]),
      .pre_out   (pre[i+1]),
      .cmd       (cell_cmd[i]),
      .pay       (cell_pay[i])
    );
  end

  // Advance fill count and timer on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      timer_left <= '0;
    end else if (accept) begin
      count      <= count_next;
      timer_left <= timer_left_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.send_valid   <= send;
      rsp.send_command <= send ? send_cmd : '0;
      rsp.send_payload <= send ? PORT_PAY_W'(send_pay) : '0;
      rsp.queued_count <= count_wide[QCNT_W-1:0];
      rsp.dropped      <= drop;
    end
  end

endmodule

FILE: hdl/pccq_cfg.sv
// APB-style register port holding the pacing interval.
// Depends on pccq_pkg for the register index and reset value.
module pccq_cfg import pccq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [TIMER_W-1:0] interval
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PACING);

  // Write the interval on the access cycle of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= PACING_RESET;
    end else if (wr_en) begin
      interval <= pwdata[TIMER_W-1:0];
    end
  end

  // Read back; unmapped word reads as zero
  assign prdata = (paddr[2] == REG_PACING) ? 32'(interval) : 32'd0;

endmodule

FILE: hdl/pccq_cell.sv
// One queue slot: holds a command code and payload, compares its code with
// the submit, and loads from itself, its two successors or the new command.
// Depends on pccq_pkg for the control struct.
module pccq_cell import pccq_pkg::*; #(
  parameter int IDX    = 0,
  parameter int CW     = 4,
  parameter int PAY_W  = 32
) (
  input  logic             clk,
  input  pccq_ctl_t        ctl,
  input  logic [CW-1:0]    count,      // entries before this item
  input  logic [CW-1:0]    kept,       // entries left after coalescing
  input  logic [PAY_W-1:0] new_pay,
  input  logic [CMD_W-1:0] next_cmd,
  input  logic [PAY_W-1:0] next_pay,
  input  logic [CMD_W-1:0] next2_cmd,
  input  logic [PAY_W-1:0] next2_pay,
  input  logic             pre_in,     // a match sits before this slot
  input  logic             pre_next,   // a match sits at or before the next slot
  output logic             pre_out,    // a match sits at or before this slot
  output logic [CMD_W-1:0] cmd,
  output logic [PAY_W-1:0] pay
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

  logic             match;
  logic [CMD_W-1:0] cmd_next;
  logic [PAY_W-1:0] pay_next;

  // Tag compare on an occupied slot
  assign match   = ctl.submit && (IDX_C < count) && (cmd == ctl.code);
  assign pre_out = pre_in || match;

  // Pick the source: skip the match, skip the front on a pop, or append
  always_comb begin
    cmd_next = cmd;
    pay_next = pay;
    if (ctl.pop) begin
      if (ctl.append && (IDX1_C == kept)) begin
        cmd_next = ctl.code;
        pay_next = new_pay;
      end else if (pre_next) begin
        cmd_next = next2_cmd;
        pay_next = next2_pay;
      end else begin
        cmd_next = next_cmd;
        pay_next = next_pay;
      end
    end else begin
      if (ctl.append && (IDX_C == kept)) begin
        cmd_next = ctl.code;
        pay_next = new_pay;
      end else if (pre_out) begin
        cmd_next = next_cmd;
        pay_next = next_pay;
      end
    end
  end

  // Hold unless the sequencer moves the queue
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      cmd <= cmd_next;
      pay <= pay_next;
    end
  end

endmodule
